[design/iebb_pkg.sv]
// Shared types, constants and coefficient ROM builder for the equalizer band bank.
package iebb_pkg;

  localparam int FILTER_ORDER_DEF   = 8;
  localparam int NUM_BANDS_DEF      = 9;
  localparam int COEF_FRAC_BITS_DEF = 48;

  localparam int MAX_BANDS   = 9;
  localparam int DESIGN_TAPS = 9;
  localparam int SAMPLE_W    = 24;
  localparam int IDX_W       = 4;
  localparam int OPND_W      = 64;
  localparam int ACC_W       = 128;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [IDX_W-1:0] RAW_INDEX = 4'd9;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [MAX_BANDS-1:0]       mask;
  } queue_entry_t;

  typedef struct packed {
    logic                     v;
    logic                     clr;
    logic                     sub;
    logic signed [OPND_W-1:0] coef;
    logic signed [OPND_W-1:0] opnd;
  } mac_op_t;

  // b[0..8] then a[0..8] per band
  localparam int DESIGN_M [MAX_BANDS][2*DESIGN_TAPS] = '{
    '{5433485, 0, -2173394, 0, 3260091, 0, -2173394, 0, 5433485,
      1, -7974683, 27823104, -55470284, 69118758, -55120371, 27473188, -7824717, 975005},
    '{5732219, 0, -2292888, 0, 3439331, 0, -2292888, 0, 5732219,
      1, -7973150, 27813599, -55445413, 69083338, -55090945, 27459106, -7821207, 974672},
    '{1001672, 0, -4006688, 0, 6010032, 0, -4006688, 0, 1001672,
      1, -7899502, 27307816, -53956734, 66649036, -52702550, 26053079, -7361362, 910217},
    '{8623441, 0, -3449377, 0, 5174065, 0, -3449377, 0, 8623441,
      1, -7804813, 26683846, -52196377, 63893368, -50118108, 24601279, -6909204, 850009},
    '{5123206, 0, -2049282, 0, 3073924, 0, -2049282, 0, 5123206,
      1, -7627606, 25568630, -49195004, 59420390, -46136845, 22488660, -6291852, 773628},
    '{1297441, 0, -5189762, 0, 7784644, 0, -5189762, 0, 1297441,
      1, -6929411, 21441837, -38661455, 44407950, -33269803, 15879107, -4416762, 548734},
    '{2057067, 0, -8228267, 0, 12342401, 0, -8228267, 0, 2057067,
      1, -4980276, 12102712, -18292451, 18713369, -13218292, 6315977, -1876329, 273038},
    '{1693903, 0, -6775614, 0, 10163421, 0, -6775614, 0, 1693903,
      1, -411036, 1701700, -558813, 1407597, -312091, 537295, -61876, 82318},
    '{2606726, 0, -10426906, 0, 15640359, 0, -10426906, 0, 2606726,
      1, 5306533, 12256812, 16324236, 13915414, 7826736, 2815098, 585605, 55786}
  };

  localparam int DESIGN_E [MAX_BANDS][2*DESIGN_TAPS] = '{
    '{16, 0, 15, 0, 15, 0, 15, 0, 16, 0, 6, 6, 6, 6, 6, 6, 6, 6},
    '{16, 0, 15, 0, 15, 0, 15, 0, 16, 0, 6, 6, 6, 6, 6, 6, 6, 6},
    '{13, 0, 13, 0, 13, 0, 13, 0, 13, 0, 6, 6, 6, 6, 6, 6, 6, 6},
    '{13, 0, 12, 0, 12, 0, 12, 0, 13, 0, 6, 6, 6, 6, 6, 6, 6, 6},
    '{12, 0, 11, 0, 11, 0, 11, 0, 12, 0, 6, 6, 6, 6, 6, 6, 6, 6},
    '{10, 0, 10, 0, 10, 0, 10, 0, 10, 0, 6, 6, 6, 6, 6, 6, 6, 6},
    '{9, 0, 9, 0, 9, 0, 9, 0, 9, 0, 6, 6, 6, 6, 6, 6, 6, 6},
    '{8, 0, 8, 0, 8, 0, 8, 0, 8, 0, 6, 6, 6, 6, 6, 6, 6, 6},
    '{8, 0, 8, 0, 8, 0, 8, 0, 8, 0, 6, 6, 6, 6, 6, 6, 6, 6}
  };

  function automatic logic signed [OPND_W-1:0] rom_coef(int band, int tap, bit fb, int frac);
    logic [127:0] n;
    logic [63:0]  d;
    logic [63:0]  q;
    logic [63:0]  r;
    logic [63:0]  mag;
    int           m;
    int           e;
    int           idx;
    if (tap >= DESIGN_TAPS) begin
      return '0;
    end
    idx = fb ? DESIGN_TAPS + tap : tap;
    m   = DESIGN_M[band][idx];
    e   = DESIGN_E[band][idx];
    d   = 64'd1;
    for (int k = 0; k < e; k++) begin
      d = d * 64'd10;
    end
    mag = (m < 0) ? 64'(-m) : 64'(m);
    n   = (128'(mag) << frac) + 128'(d >> 1);
    q   = '0;
    r   = '0;
    for (int bit_i = 127; bit_i >= 0; bit_i--) begin
      r = {r[62:0], n[bit_i]};
      q = {q[62:0], 1'b0};
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return (m < 0) ? -$signed(q) : $signed(q);
  endfunction

endpackage

[design/iir_equalizer_band_bank_top.sv]
// Top level of the IIR equalizer band bank.
// The back end filters one queued word at a time, band after band, on the one shared
// multiply-accumulate unit; the front end and queue can accept further words meanwhile.
// Reset: synchronous active low; clears band enables, histories, queue and output register.
module iir_equalizer_band_bank_top #(
  parameter int FILTER_ORDER   = iebb_pkg::FILTER_ORDER_DEF,
  parameter int NUM_BANDS      = iebb_pkg::NUM_BANDS_DEF,
  parameter int COEF_FRAC_BITS = iebb_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [iebb_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  logic                                  cfg_we,
  input  logic [iebb_pkg::MAX_BANDS-1:0]        cfg_band_enable,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [iebb_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic [iebb_pkg::IDX_W-1:0]            out_band_index,
  output logic                                  out_last_of_run
);

  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_empty;
  iebb_pkg::queue_entry_t q_wr;
  iebb_pkg::queue_entry_t q_rd;

  iebb_front #(
    .NUM_BANDS (NUM_BANDS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_in    (in_sample_in),
    .cfg_we          (cfg_we),
    .cfg_band_enable (cfg_band_enable),
    .q_push          (q_push),
    .q_entry         (q_wr),
    .q_full          (q_full)
  );

  iebb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (q_rd),
    .empty    (q_empty)
  );

  iebb_back #(
    .FILTER_ORDER   (FILTER_ORDER),
    .NUM_BANDS      (NUM_BANDS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_entry         (q_rd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample_out  (out_sample_out),
    .out_band_index  (out_band_index),
    .out_last_of_run (out_last_of_run)
  );

endmodule

[design/iebb_front.sv]
// Front end: band enable register, input word capture and queue push.
module iebb_front #(
  parameter int NUM_BANDS = iebb_pkg::NUM_BANDS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [iebb_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  logic                                  cfg_we,
  input  logic [iebb_pkg::MAX_BANDS-1:0]        cfg_band_enable,
  output logic                                  q_push,
  output iebb_pkg::queue_entry_t                q_entry,
  input  logic                                  q_full
);

  logic [iebb_pkg::MAX_BANDS-1:0] band_enable_r;
  logic                           hold_v_r;
  iebb_pkg::queue_entry_t         hold_r;
  logic [iebb_pkg::MAX_BANDS-1:0] live_mask;

  assign live_mask = band_enable_r &
                     iebb_pkg::MAX_BANDS'((1 << NUM_BANDS) - 1);
  assign in_ready  = !hold_v_r;
  assign q_push    = hold_v_r && !q_full;
  assign q_entry   = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_enable_r <= '0;
      hold_v_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        band_enable_r <= cfg_band_enable;
      end
      if (in_valid && in_ready) begin
        hold_v_r      <= 1'b1;
        hold_r.sample <= in_sample_in;
        hold_r.mask   <= live_mask;
      end else if (q_push) begin
        hold_v_r <= 1'b0;
      end
    end
  end

endmodule

[design/iebb_queue.sv]
// Short queue of accepted words between front and back.
module iebb_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  iebb_pkg::queue_entry_t wr_entry,
  output logic                   full,
  input  logic                   pop,
  output iebb_pkg::queue_entry_t rd_entry,
  output logic                   empty
);

  localparam int DEPTH = iebb_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  iebb_pkg::queue_entry_t slot_r [DEPTH];
  logic [PW-1:0]          wp_r;
  logic [PW-1:0]          rp_r;
  logic [CW-1:0]          cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign rd_entry = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[design/iebb_mac.sv]
// Pipelined 64x64 multiply-accumulate built from four 33x33 partial products.
module iebb_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  iebb_pkg::mac_op_t                   op,
  output logic signed [iebb_pkg::ACC_W-1:0]   acc
);

  localparam int AW = iebb_pkg::ACC_W;

  logic signed [32:0] a_lo, a_hi, b_lo, b_hi;
  logic signed [65:0] p_ll_r, p_lh_r, p_hl_r, p_hh_r;
  logic               s1_v_r, s1_clr_r, s1_sub_r;
  logic signed [AW-1:0] prod_r;
  logic               s2_v_r, s2_clr_r, s2_sub_r;
  logic signed [AW-1:0] prod_sum;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] acc_base;
  logic signed [AW-1:0] addend;

  assign a_lo = $signed({1'b0, op.coef[31:0]});
  assign a_hi = $signed({op.coef[63], op.coef[63:32]});
  assign b_lo = $signed({1'b0, op.opnd[31:0]});
  assign b_hi = $signed({op.opnd[63], op.opnd[63:32]});

  assign prod_sum = (AW'(p_hh_r) <<< 64) + (AW'(p_hl_r) <<< 32) +
                    (AW'(p_lh_r) <<< 32) + AW'(p_ll_r);

  assign acc_base = s2_clr_r ? '0 : acc_r;
  assign addend   = s2_sub_r ? ~prod_r : prod_r;
  assign acc      = acc_r;

  always_ff @(posedge clk) begin
    p_ll_r <= a_lo * b_lo;
    p_lh_r <= a_lo * b_hi;
    p_hl_r <= a_hi * b_lo;
    p_hh_r <= a_hi * b_hi;
    prod_r <= prod_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      acc_r  <= '0;
    end else begin
      s1_v_r   <= op.v;
      s1_clr_r <= op.clr;
      s1_sub_r <= op.sub;
      s2_v_r   <= s1_v_r;
      s2_clr_r <= s1_clr_r;
      s2_sub_r <= s1_sub_r;
      if (s2_v_r) begin
        acc_r <= acc_base + addend + AW'(s2_sub_r);
      end
    end
  end

endmodule

[design/iebb_back.sv]
// Back end: band sequencer, history memories, coefficient ROM and result register.
module iebb_back #(
  parameter int FILTER_ORDER   = iebb_pkg::FILTER_ORDER_DEF,
  parameter int NUM_BANDS      = iebb_pkg::NUM_BANDS_DEF,
  parameter int COEF_FRAC_BITS = iebb_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_empty,
  input  iebb_pkg::queue_entry_t                q_entry,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [iebb_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic [iebb_pkg::IDX_W-1:0]            out_band_index,
  output logic                                  out_last_of_run
);

  localparam int ORDER  = FILTER_ORDER;
  localparam int HIST_N = NUM_BANDS * ORDER;
  localparam int ROMB_N = NUM_BANDS * (ORDER + 1);
  localparam int HAW    = (HIST_N > 1) ? $clog2(HIST_N) : 1;
  localparam int RBW    = $clog2(ROMB_N);
  localparam int SW     = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int BW     = $clog2(NUM_BANDS + 1);
  localparam int BIW    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int STEPS  = 2 * ORDER;
  localparam int STW    = $clog2(STEPS + 1);
  localparam int SHW    = iebb_pkg::ACC_W - COEF_FRAC_BITS;
  localparam int SW24   = iebb_pkg::SAMPLE_W;
  localparam int OW     = iebb_pkg::OPND_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_RUN, ST_DRAIN, ST_FIN, ST_WB, ST_RAW
  } state_t;

  logic signed [OW-1:0] rom_b [ROMB_N];
  logic signed [OW-1:0] rom_a [HIST_N];

  for (genvar g = 0; g < ROMB_N; g++) begin : g_romb
    assign rom_b[g] = iebb_pkg::rom_coef(g / (ORDER + 1), g % (ORDER + 1), 1'b0,
                                         COEF_FRAC_BITS);
  end
  for (genvar g = 0; g < HIST_N; g++) begin : g_roma
    assign rom_a[g] = iebb_pkg::rom_coef(g / ORDER, g % ORDER + 1, 1'b1, COEF_FRAC_BITS);
  end

  logic signed [SW24-1:0] xh_mem [HIST_N];
  logic signed [OW-1:0]   yh_mem [HIST_N];

  state_t                 state_r;
  logic [BW-1:0]          band_r;
  logic [STW-1:0]         step_r;
  logic [1:0]             drain_r;
  logic [NUM_BANDS-1:0]   mask_r;
  logic signed [SW24-1:0] x_r;
  logic signed [OW-1:0]   y_r;
  logic [HIST_N-1:0]      hv_r;
  logic [SW-1:0]          ptr_r [NUM_BANDS];
  logic signed [SW24-1:0] xr_r;
  logic signed [OW-1:0]   yr_r;
  logic                   rv_r;
  iebb_pkg::mac_op_t      op_r;
  iebb_pkg::mac_op_t      op_nxt;
  logic                   out_v_r;
  logic signed [SW24-1:0] out_s_r;
  logic [iebb_pkg::IDX_W-1:0] out_i_r;
  logic                   out_l_r;

  logic [BIW-1:0]         bsel;
  logic [SW:0]            kk;
  logic [SW:0]            ssum;
  logic [SW-1:0]          rslot;
  logic [SW-1:0]          wslot;
  logic [HAW-1:0]         raddr;
  logic [HAW-1:0]         waddr;
  logic                   rd_en;
  logic                   wr_en;
  logic [RBW-1:0]         rb_idx;
  logic [HAW-1:0]         ra_idx;
  logic signed [OW-1:0]   xd_ext;
  logic signed [OW-1:0]   yd;
  logic signed [iebb_pkg::ACC_W-1:0] acc;
  logic signed [SHW-1:0]  shifted;
  logic                   fits;
  logic signed [OW-1:0]   y_nxt;
  logic signed [OW-1:0]   tz_full;
  logic signed [31:0]     tz;
  logic signed [SW24-1:0] band_out;
  logic                   out_free;

  assign bsel   = band_r[BIW-1:0];
  assign kk     = (SW + 1)'(step_r >> 1);
  assign ssum   = {1'b0, ptr_r[bsel]} + kk;
  assign rslot  = (ssum >= (SW + 1)'(ORDER)) ? SW'(ssum - (SW + 1)'(ORDER)) : SW'(ssum);
  assign wslot  = (ptr_r[bsel] == '0) ? SW'(ORDER - 1) : ptr_r[bsel] - 1'b1;
  assign raddr  = HAW'(int'(bsel) * ORDER + int'(rslot));
  assign waddr  = HAW'(int'(bsel) * ORDER + int'(wslot));
  assign rd_en  = (state_r == ST_RUN) && !step_r[0] && (kk < (SW + 1)'(ORDER));
  assign out_free = !out_v_r || out_ready;
  assign wr_en  = (state_r == ST_WB) && out_free;

  assign rb_idx = RBW'(int'(bsel) * (ORDER + 1) + int'((step_r + 1'b1) >> 1));
  assign ra_idx = (step_r == '0) ? '0 : HAW'(int'(bsel) * ORDER + int'(step_r >> 1) - 1);

  assign xd_ext = rv_r ? {{(OW - SW24 - 32){xr_r[SW24-1]}}, xr_r, 32'b0} : '0;
  assign yd     = rv_r ? yr_r : '0;

  always_comb begin
    op_nxt.v   = (state_r == ST_RUN);
    op_nxt.clr = (step_r == '0);
    op_nxt.sub = 1'b0;
    op_nxt.coef = rom_b[rb_idx];
    op_nxt.opnd = xd_ext;
    if (step_r == '0) begin
      op_nxt.opnd = {{(OW - SW24 - 32){x_r[SW24-1]}}, x_r, 32'b0};
    end else if (!step_r[0]) begin
      op_nxt.sub  = 1'b1;
      op_nxt.coef = rom_a[ra_idx];
      op_nxt.opnd = yd;
    end
  end

  iebb_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op_r),
    .acc   (acc)
  );

  assign shifted = SHW'(acc >>> COEF_FRAC_BITS);
  assign fits    = (shifted[SHW-1:OW-1] == '0) || (shifted[SHW-1:OW-1] == '1);
  assign y_nxt   = fits ? shifted[OW-1:0] :
                   (shifted[SHW-1] ? {1'b1, {(OW - 1){1'b0}}} : {1'b0, {(OW - 1){1'b1}}});

  assign tz_full = y_r[OW-1] ? ((y_r + OW'(64'h0000_0000_FFFF_FFFF)) >>> 32) : (y_r >>> 32);
  assign tz      = tz_full[31:0];

  always_comb begin
    if (tz > 32'sd8388607) begin
      band_out = 24'sh7FFFFF;
    end else if (tz < -32'sd8388608) begin
      band_out = -24'sh800000;
    end else begin
      band_out = tz[SW24-1:0];
    end
  end

  assign q_pop           = (state_r == ST_IDLE) && !q_empty;
  assign out_valid       = out_v_r;
  assign out_sample_out  = out_s_r;
  assign out_band_index  = out_i_r;
  assign out_last_of_run = out_l_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      xh_mem[waddr] <= x_r;
      yh_mem[waddr] <= y_r;
    end
    if (rd_en) begin
      xr_r <= xh_mem[raddr];
      yr_r <= yh_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      band_r  <= '0;
      step_r  <= '0;
      drain_r <= '0;
      hv_r    <= '0;
      rv_r    <= 1'b0;
      op_r.v  <= 1'b0;
      out_v_r <= 1'b0;
      for (int i = 0; i < NUM_BANDS; i++) begin
        ptr_r[i] <= '0;
      end
    end else begin
      op_r <= op_nxt;
      if (rd_en) begin
        rv_r <= hv_r[raddr];
      end
      if (out_v_r && out_ready) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            x_r     <= q_entry.sample;
            mask_r  <= q_entry.mask[NUM_BANDS-1:0];
            band_r  <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          priority if (band_r == BW'(NUM_BANDS)) begin
            state_r <= ST_RAW;
          end else if (mask_r[bsel]) begin
            step_r  <= '0;
            state_r <= ST_RUN;
          end else begin
            band_r <= band_r + 1'b1;
          end
        end
        ST_RUN: begin
          step_r <= step_r + 1'b1;
          if (step_r == STW'(STEPS)) begin
            drain_r <= '0;
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_r <= drain_r + 1'b1;
          if (drain_r == 2'd2) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          y_r     <= y_nxt;
          state_r <= ST_WB;
        end
        ST_WB: begin
          if (out_free) begin
            out_v_r      <= 1'b1;
            out_s_r      <= band_out;
            out_i_r      <= iebb_pkg::IDX_W'(band_r);
            out_l_r      <= 1'b0;
            hv_r[waddr]  <= 1'b1;
            ptr_r[bsel]  <= wslot;
            band_r       <= band_r + 1'b1;
            state_r      <= ST_SCAN;
          end
        end
        ST_RAW: begin
          if (out_free) begin
            out_v_r <= 1'b1;
            out_s_r <= x_r;
            out_i_r <= iebb_pkg::RAW_INDEX;
            out_l_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/testbench.sv]
// Testbench for the IIR equalizer band bank: queued driver, checking monitor, phased configuration.
`timescale 1ns / 1ps
module testbench;

  localparam int NB = 9;
  localparam int ORD = 8;
  localparam int FRAC = 48;
  localparam int LIMIT = 2000000;
  localparam int SETTLE = 300;

  typedef struct {
    logic signed [iebb_pkg::SAMPLE_W-1:0] sample;
    logic [iebb_pkg::IDX_W-1:0]           band;
    logic                                 last;
  } band_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [iebb_pkg::SAMPLE_W-1:0] in_sample_in = '0;
  logic cfg_we = 1'b0;
  logic [iebb_pkg::MAX_BANDS-1:0] cfg_band_enable = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [iebb_pkg::SAMPLE_W-1:0] out_sample_out;
  logic [iebb_pkg::IDX_W-1:0] out_band_index;
  logic out_last_of_run;

  logic signed [iebb_pkg::SAMPLE_W-1:0] pending_samples[$];
  band_word_t expected_words[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fed_count = 0;
  int word_count = 0;
  int mismatches = 0;
  int cycles = 0;
  int hold_cnt = 0;
  bit held_once = 0;

  logic [iebb_pkg::MAX_BANDS-1:0] enable_mask;
  logic signed [63:0] x_hist[NB][ORD];
  logic signed [63:0] y_hist[NB][ORD];
  logic signed [63:0] b_coef[NB][ORD+1];
  logic signed [63:0] a_coef[NB][ORD];

  iir_equalizer_band_bank_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample_in(in_sample_in),
    .cfg_we(cfg_we), .cfg_band_enable(cfg_band_enable),
    .out_valid(out_valid), .out_ready(out_ready), .out_sample_out(out_sample_out),
    .out_band_index(out_band_index), .out_last_of_run(out_last_of_run)
  );

  always #6 clk = ~clk;

  function automatic logic signed [63:0] fixed_coef(int m, int e);
    logic [127:0] num;
    logic [127:0] div;
    logic [127:0] quo;
    logic [63:0]  mag;
    div = 128'd1;
    for (int k = 0; k < e; k++) div = div * 128'd10;
    mag = (m < 0) ? 64'(-m) : 64'(m);
    num = (128'(mag) << FRAC) + (div >> 1);
    quo = num / div;
    return (m < 0) ? -$signed(quo[63:0]) : $signed(quo[63:0]);
  endfunction

  function automatic logic signed [iebb_pkg::SAMPLE_W-1:0] filter_band(int bd,
                                                                      logic signed [63:0] x);
    logic signed [127:0] acc;
    logic signed [127:0] pa;
    logic signed [127:0] pb;
    logic signed [127:0] sh;
    logic signed [63:0]  y;
    logic [63:0]         mg;
    longint              ip;
    pa = b_coef[bd][0];
    pb = x;
    acc = (pa * pb) <<< 32;
    for (int k = 0; k < ORD; k++) begin
      pa = b_coef[bd][k+1];
      pb = x_hist[bd][k];
      acc = acc + ((pa * pb) <<< 32);
      pa = a_coef[bd][k];
      pb = y_hist[bd][k];
      acc = acc - pa * pb;
    end
    sh = acc >>> FRAC;
    if (sh[127:63] == '0 || sh[127:63] == '1) y = sh[63:0];
    else y = sh[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    for (int k = ORD - 1; k > 0; k--) begin
      x_hist[bd][k] = x_hist[bd][k-1];
      y_hist[bd][k] = y_hist[bd][k-1];
    end
    x_hist[bd][0] = x;
    y_hist[bd][0] = y;
    mg = y[63] ? 64'(-y) : 64'(y);
    mg = mg >> 32;
    ip = y[63] ? -longint'(mg) : longint'(mg);
    if (ip > 8388607) ip = 8388607;
    if (ip < -8388608) ip = -8388608;
    return ip[iebb_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic predict_bands(logic signed [iebb_pkg::SAMPLE_W-1:0] s);
    band_word_t w;
    for (int bd = 0; bd < NB; bd++) begin
      if (enable_mask[bd]) begin
        w.sample = filter_band(bd, 64'(s));
        w.band = iebb_pkg::IDX_W'(bd);
        w.last = 1'b0;
        expected_words.push_back(w);
      end
    end
    w.sample = s;
    w.band = iebb_pkg::RAW_INDEX;
    w.last = 1'b1;
    expected_words.push_back(w);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_bands(in_sample_in);
        fed_count++;
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_sample_in <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !held_once && fed_count >= 200) begin
      held_once <= 1'b1;
      hold_cnt <= 3000;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    band_word_t w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        word_count++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: sample %0d band %0d last %0d",
                     out_sample_out, out_band_index, out_last_of_run);
        end else begin
          w = expected_words.pop_front();
          if (w.sample !== out_sample_out || w.band !== out_band_index ||
              w.last !== out_last_of_run) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                       w.sample, w.band, w.last,
                       out_sample_out, out_band_index, out_last_of_run);
          end
        end
      end
      out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_mask(logic [iebb_pkg::MAX_BANDS-1:0] m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_band_enable <= m;
    enable_mask = m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(logic [iebb_pkg::MAX_BANDS-1:0] m, int idle, int stall, int n);
    write_mask(m);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: pending_samples.push_back(iebb_pkg::SAMPLE_W'($urandom_range(4095) - 2048));
        1: pending_samples.push_back($urandom_range(1) ? 24'sh7FFFFF : 24'sh800000);
        default: pending_samples.push_back(iebb_pkg::SAMPLE_W'($urandom));
      endcase
    end
    drain();
  endtask

  initial begin
    for (int bd = 0; bd < NB; bd++) begin
      for (int k = 0; k <= ORD; k++)
        b_coef[bd][k] = fixed_coef(iebb_pkg::DESIGN_M[bd][k], iebb_pkg::DESIGN_E[bd][k]);
      for (int k = 0; k < ORD; k++)
        a_coef[bd][k] = fixed_coef(iebb_pkg::DESIGN_M[bd][iebb_pkg::DESIGN_TAPS+k+1],
                                   iebb_pkg::DESIGN_E[bd][iebb_pkg::DESIGN_TAPS+k+1]);
      for (int k = 0; k < ORD; k++) begin
        x_hist[bd][k] = '0;
        y_hist[bd][k] = '0;
      end
    end
    enable_mask = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    pending_samples.push_back(24'sh000001);
    pending_samples.push_back(24'sh7FFFFF);
    drain();
    write_mask(9'h1FF);
    pending_samples.push_back(24'sh7FFFFF);
    for (int i = 0; i < 8; i++) pending_samples.push_back('0);
    pending_samples.push_back(24'sh800000);
    pending_samples.push_back(24'sh7FFFFF);
    pending_samples.push_back(24'sh800000);
    pending_samples.push_back(-24'sd1);
    pending_samples.push_back(24'sd1);
    for (int i = 0; i < 6; i++) pending_samples.push_back(24'sh7FFFFF);
    drain();
    write_mask(9'h001);
    pending_samples.push_back(24'sh555555);
    pending_samples.push_back(24'shAAAAAA);
    drain();

    random_phase(9'h1FF, 0, 0, 60);
    random_phase(9'h100, 49, 0, 50);
    random_phase(iebb_pkg::MAX_BANDS'($urandom), 0, 49, 60);
    random_phase(9'h000, 14, 14, 40);
    random_phase(iebb_pkg::MAX_BANDS'($urandom), 49, 0, 50);
    random_phase(9'h1FF, 0, 49, 60);
    random_phase(iebb_pkg::MAX_BANDS'($urandom), 14, 14, 60);
    random_phase(9'h0AA, 0, 0, 50);

    $display("covered %0d input words and %0d result words over several band masks,",
             fed_count, word_count);
    $display("with sender gaps, receiver stalls and one long output hold-off");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
